// ===== rtl/core/scts_pkg.sv =====
// shared types and constants for the serial command trigger scheduler
package scts_pkg;

   // command bytes
   localparam logic [7:0] CMD_PERIOD   = 8'h66;
   localparam logic [7:0] CMD_PAUSE    = 8'h70;
   localparam logic [7:0] CMD_RESUME   = 8'h72;
   localparam logic [7:0] CMD_SINGLE   = 8'h74;
   localparam logic [7:0] CMD_INTERVAL = 8'h64;

   // event kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam int PERIOD_W   = 8;
   localparam int INTERVAL_W = 14;
   localparam int RELOAD_W   = 14;
   localparam int CLOCK_W    = 8;

   localparam logic [PERIOD_W-1:0]   PERIOD_MIN     = 8'd5;
   localparam logic [PERIOD_W-1:0]   PERIOD_MAX     = 8'd250;
   localparam logic [15:0]           INTERVAL_MIN   = 16'd100;
   localparam logic [15:0]           INTERVAL_MAX   = 16'd10000;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 8'd33;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 14'd218;
   localparam logic [RELOAD_W-1:0]   RELOAD_RESET   = 14'd51;
   localparam logic [7:0]            ELAPSED_MAX    = 8'd255;

   // divide by 1000 as a multiply by ceil(2^32 / 1000), exact for products below 2^22
   localparam int unsigned NS_PER_US   = 1000;
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned RECIP       = 4294968;
   localparam int unsigned CLOCK_RESET = 240;
   localparam int SCALE_W = 31;
   localparam int PROD_W  = SCALE_W + INTERVAL_W;
   localparam int TICKS_W = PROD_W - RECIP_SHIFT;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(CLOCK_RESET * RECIP);

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } event_type;

   typedef struct packed {
      logic                  fire_single;
      logic                  fire_periodic;
      logic [PERIOD_W-1:0]   period_ms;
      logic                  running;
      logic [INTERVAL_W-1:0] sample_interval_ns;
      logic [RELOAD_W-1:0]   timer_reload;
   } result_type;

endpackage

// ===== rtl/core/scts_req_if.sv =====
// request channel: command bytes and millisecond ticks
interface scts_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;

   modport source (output valid, output kind, output byte_value, input ready);
   modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

// ===== rtl/core/scts_rsp_if.sv =====
// response channel: trigger flags and current settings
interface scts_rsp_if;
   logic        valid;
   logic        ready;
   logic        fire_single;
   logic        fire_periodic;
   logic [7:0]  period_ms;
   logic        running;
   logic [13:0] sample_interval_ns;
   logic [13:0] timer_reload;

   modport source (output valid, output fire_single, output fire_periodic,
                   output period_ms, output running, output sample_interval_ns,
                   output timer_reload, input ready);
   modport sink   (input valid, input fire_single, input fire_periodic,
                   input period_ms, input running, input sample_interval_ns,
                   input timer_reload, output ready);
endinterface

// ===== rtl/core/scts_csr_if.sv =====
// configuration write channel for the timer clock register
interface scts_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/scts_cfg.sv =====
// timer clock register, held as clock times the reciprocal of 1000
module scts_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            write_en,
   input  logic [scts_pkg::CLOCK_W-1:0]    write_data,
   output logic [scts_pkg::SCALE_W-1:0]    scale
);

   logic [scts_pkg::SCALE_W-1:0] scale_ff;
   logic [scts_pkg::SCALE_W-1:0] scale_in;

   always_comb begin
      scale_in = scale_ff;
      if (write_en) begin
         scale_in = scts_pkg::SCALE_W'(32'(write_data) * scts_pkg::RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= scts_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   assign scale = scale_ff;

endmodule

// ===== rtl/core/scts_engine.sv =====
// command parser, trigger state and reload calculation
module scts_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  scts_pkg::event_type          ev,
   input  logic [scts_pkg::SCALE_W-1:0] scale,
   output scts_pkg::result_type         result
);

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_PERIOD   = 2'd1,
      MODE_INTERVAL = 2'd2
   } mode_type;

   mode_type                            mode_ff, mode_in;
   logic [7:0]                          low_byte_ff, low_byte_in;
   logic                                byte_count_ff, byte_count_in;
   logic [scts_pkg::PERIOD_W-1:0]       period_ff, period_in;
   logic                                active_ff, active_in;
   logic                                pending_ff, pending_in;
   logic [scts_pkg::INTERVAL_W-1:0]     interval_ff, interval_in;
   logic [scts_pkg::RELOAD_W-1:0]       reload_ff, reload_in;
   logic [7:0]                          elapsed_ff, elapsed_in;

   logic [15:0]                         word;
   logic                                word_ok;
   logic [scts_pkg::PROD_W-1:0]         prod;
   logic [scts_pkg::TICKS_W-1:0]        ticks;
   logic [scts_pkg::RELOAD_W-1:0]       new_reload;
   logic [7:0]                          elapsed_up;
   logic                                fire_s, fire_p;

   // interval word and its reload value
   assign word    = {ev.byte_value, low_byte_ff};
   assign word_ok = (word >= scts_pkg::INTERVAL_MIN) && (word <= scts_pkg::INTERVAL_MAX);
   assign prod    = scts_pkg::PROD_W'(word[scts_pkg::INTERVAL_W-1:0])
                  * scts_pkg::PROD_W'(scale);
   assign ticks   = prod[scts_pkg::PROD_W-1:scts_pkg::RECIP_SHIFT];
   assign new_reload = (ticks != '0) ? scts_pkg::RELOAD_W'(ticks - 1'b1) : '0;

   assign elapsed_up = (elapsed_ff < scts_pkg::ELAPSED_MAX) ? elapsed_ff + 8'd1 : elapsed_ff;

   always_comb begin
      mode_in       = mode_ff;
      low_byte_in   = low_byte_ff;
      byte_count_in = byte_count_ff;
      period_in     = period_ff;
      active_in     = active_ff;
      pending_in    = pending_ff;
      interval_in   = interval_ff;
      reload_in     = reload_ff;
      elapsed_in    = elapsed_ff;
      fire_s        = 1'b0;
      fire_p        = 1'b0;
      if (step) begin
         if (ev.kind == scts_pkg::KIND_BYTE) begin
            case (mode_ff)
               MODE_IDLE: begin
                  case (ev.byte_value)
                     scts_pkg::CMD_PERIOD:   mode_in = MODE_PERIOD;
                     scts_pkg::CMD_PAUSE:    active_in = 1'b0;
                     scts_pkg::CMD_RESUME:   active_in = 1'b1;
                     scts_pkg::CMD_SINGLE:   pending_in = 1'b1;
                     scts_pkg::CMD_INTERVAL: begin
                        mode_in       = MODE_INTERVAL;
                        byte_count_in = 1'b0;
                     end
                     default: ;
                  endcase
               end
               MODE_PERIOD: begin
                  if (ev.byte_value >= scts_pkg::PERIOD_MIN &&
                      ev.byte_value <= scts_pkg::PERIOD_MAX) begin
                     period_in = ev.byte_value;
                  end
                  mode_in = MODE_IDLE;
               end
               MODE_INTERVAL: begin
                  if (!byte_count_ff) begin
                     low_byte_in   = ev.byte_value;
                     byte_count_in = 1'b1;
                  end else begin
                     if (word_ok) begin
                        interval_in = word[scts_pkg::INTERVAL_W-1:0];
                        reload_in   = new_reload;
                     end
                     byte_count_in = 1'b0;
                     mode_in       = MODE_IDLE;
                  end
               end
               default: mode_in = MODE_IDLE;
            endcase
         end else begin
            if (pending_ff) begin
               pending_in = 1'b0;
               fire_s     = 1'b1;
            end
            elapsed_in = elapsed_up;
            if (active_ff && elapsed_up >= period_ff) begin
               fire_p     = 1'b1;
               elapsed_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         low_byte_ff   <= '0;
         byte_count_ff <= 1'b0;
         period_ff     <= scts_pkg::PERIOD_RESET;
         active_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         interval_ff   <= scts_pkg::INTERVAL_RESET;
         reload_ff     <= scts_pkg::RELOAD_RESET;
         elapsed_ff    <= '0;
      end else begin
         mode_ff       <= mode_in;
         low_byte_ff   <= low_byte_in;
         byte_count_ff <= byte_count_in;
         period_ff     <= period_in;
         active_ff     <= active_in;
         pending_ff    <= pending_in;
         interval_ff   <= interval_in;
         reload_ff     <= reload_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   // fields show the state after this request
   always_comb begin
      result.fire_single        = fire_s;
      result.fire_periodic      = fire_p;
      result.period_ms          = period_in;
      result.running            = active_in;
      result.sample_interval_ns = interval_in;
      result.timer_reload       = reload_in;
   end

endmodule

// ===== rtl/core/serial_command_trigger_scheduler.sv =====
// top level of the serial command trigger scheduler
//
// req_port carries one event per request: kind 0 is a received command byte
// in byte_value, kind 1 is a one millisecond tick. Every request gives exactly
// one response on rsp_port with the single and periodic fire flags and the
// period, running flag, sample interval and timer reload after that event.
// csr_port writes the timer clock in MHz; it is always ready and only takes
// effect at the next valid interval command.
// A request is held in an input register and handled once the output register
// is free or being emptied, when its response is loaded into the output
// register; rsp valid rises after the request has passed both registers.
// One request is taken every cycle while the receiver takes responses; the
// reload multiply sits between the two registers.
// When the receiver stalls the response holds, one further request waits in
// the input register, and req ready drops only once both are full.
// Reset empties both registers and returns all settings to their defaults
// (period 33 ms, paused, interval 218 ns, reload 51, clock 240 MHz); the
// block takes requests from the first cycle after reset.
module serial_command_trigger_scheduler (
   input  logic       clock,
   input  logic       reset,
   scts_req_if.sink   req_port,
   scts_rsp_if.source rsp_port,
   scts_csr_if.sink   csr_port
);

   logic                         in_valid_ff, in_valid_in;
   scts_pkg::event_type          in_event_ff, in_event_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   scts_pkg::result_type         rsp_result_ff, rsp_result_in;

   logic                         advance;
   logic                         take;
   logic                         step;
   logic [scts_pkg::SCALE_W-1:0] scale;
   scts_pkg::result_type         result;

   assign advance = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = !in_valid_ff || advance;
   assign take = req_port.valid && req_port.ready;
   assign step = advance && in_valid_ff;
   assign csr_port.ready = 1'b1;

   scts_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .write_en   (csr_port.valid && csr_port.ready),
      .write_data (csr_port.data),
      .scale      (scale)
   );

   scts_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .ev     (in_event_ff),
      .scale  (scale),
      .result (result)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_event_in   = in_event_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (req_port.ready) begin
         in_valid_in = req_port.valid;
      end
      if (take) begin
         in_event_in.kind       = req_port.kind;
         in_event_in.byte_value = req_port.byte_value;
      end
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_event_ff   <= in_event_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.fire_single        = rsp_result_ff.fire_single;
   assign rsp_port.fire_periodic      = rsp_result_ff.fire_periodic;
   assign rsp_port.period_ms          = rsp_result_ff.period_ms;
   assign rsp_port.running            = rsp_result_ff.running;
   assign rsp_port.sample_interval_ns = rsp_result_ff.sample_interval_ns;
   assign rsp_port.timer_reload       = rsp_result_ff.timer_reload;

endmodule
